### sv/tw_odo_pkg.sv
// Shared types, codes and constants of the tracking wheel odometry block.
package tw_odo_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned DIV_STEPS  = 64;

  // pi in Q60 and the CORDIC gain in Q30
  localparam longint PI_Q60   = 64'sd3622009729038561421;
  localparam longint GAIN_Q30 = 64'sd652032874;

  typedef enum logic [2:0] {
    CFG_WHEEL_RADIUS  = 3'd0,
    CFG_RIGHT_OFFSET  = 3'd1,
    CFG_BACK_OFFSET   = 3'd2,
    CFG_START_HEADING = 3'd3,
    CFG_START_X       = 3'd4,
    CFG_START_Y       = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_HEAD, OP_MUL_R, OP_TRV_R, OP_MUL_B, OP_TRV_B, OP_PLAIN,
    OP_ARG_HALF, OP_ARG_MID, OP_HEAD_MOD, OP_MOD, OP_FOLD, OP_CORD, OP_TRIG,
    OP_CH_MUL, OP_DIV_INIT, OP_DIV, OP_CH_UMUL, OP_CH_SUM,
    OP_R1, OP_R2, OP_R3, OP_R4, OP_R5, OP_HFIX, OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_HEAD, ST_MUL_R, ST_TRV_R, ST_MUL_B, ST_TRV_B, ST_PLAIN,
    ST_ARG_HALF, ST_ARG_MID, ST_HEAD_MOD, ST_MOD, ST_FOLD, ST_CORD, ST_TRIG,
    ST_CH_MUL, ST_DIV_INIT, ST_DIV, ST_CH_UMUL, ST_CH_SUM,
    ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_HFIX, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PASS_HALF, PASS_MID, PASS_HEAD
  } pass_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] iter;
    logic       side;   // 0: back wheel / x, 1: right wheel / y
  } cmd_t;

  typedef struct packed {
    logic dth_zero;
  } sts_t;

  // pi rounded to the given number of fraction bits
  function automatic longint pi_at(input int frac);
    return (PI_Q60 + (64'sd1 <<< (59 - frac))) >>> (60 - frac);
  endfunction

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/tw_odo_ctrl.sv
// Sequencer of the odometry datapath and owner of the handshakes.
module tw_odo_ctrl #(
  parameter int unsigned CORDIC_STEPS    = 24,
  parameter int unsigned ANGLE_FRAC_BITS = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tw_odo_pkg::sts_t  sts_i,
  output tw_odo_pkg::cmd_t  cmd_o
);

  localparam int unsigned MOD_STEPS = 31 - ANGLE_FRAC_BITS;
  localparam int unsigned CW = tw_odo_pkg::CNT_W;

  tw_odo_pkg::state_e state_q, state_d;
  tw_odo_pkg::pass_e  pass_q, pass_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               side_q, side_d;
  logic               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tw_odo_pkg::ST_IDLE;
      pass_q      <= tw_odo_pkg::PASS_HALF;
      cnt_q       <= '0;
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      cnt_q       <= cnt_d;
      side_q      <= side_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    cnt_d       = cnt_q;
    side_d      = side_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = tw_odo_pkg::OP_NOP;
    cmd_o.iter  = cnt_q[4:0];
    cmd_o.side  = side_q;
    case (state_q)
      tw_odo_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tw_odo_pkg::OP_LOAD;
          state_d  = tw_odo_pkg::ST_HEAD;
        end
      end
      tw_odo_pkg::ST_HEAD: begin
        cmd_o.op = tw_odo_pkg::OP_HEAD;
        state_d  = tw_odo_pkg::ST_MUL_R;
      end
      tw_odo_pkg::ST_MUL_R: begin
        cmd_o.op = tw_odo_pkg::OP_MUL_R;
        state_d  = tw_odo_pkg::ST_TRV_R;
      end
      tw_odo_pkg::ST_TRV_R: begin
        cmd_o.op = tw_odo_pkg::OP_TRV_R;
        state_d  = tw_odo_pkg::ST_MUL_B;
      end
      tw_odo_pkg::ST_MUL_B: begin
        cmd_o.op = tw_odo_pkg::OP_MUL_B;
        state_d  = tw_odo_pkg::ST_TRV_B;
      end
      tw_odo_pkg::ST_TRV_B: begin
        cmd_o.op = tw_odo_pkg::OP_TRV_B;
        state_d  = sts_i.dth_zero ? tw_odo_pkg::ST_PLAIN : tw_odo_pkg::ST_ARG_HALF;
      end
      tw_odo_pkg::ST_PLAIN: begin
        cmd_o.op = tw_odo_pkg::OP_PLAIN;
        state_d  = tw_odo_pkg::ST_ARG_MID;
      end
      tw_odo_pkg::ST_ARG_HALF: begin
        cmd_o.op = tw_odo_pkg::OP_ARG_HALF;
        pass_d   = tw_odo_pkg::PASS_HALF;
        cnt_d    = '0;
        state_d  = tw_odo_pkg::ST_MOD;
      end
      tw_odo_pkg::ST_ARG_MID: begin
        cmd_o.op = tw_odo_pkg::OP_ARG_MID;
        pass_d   = tw_odo_pkg::PASS_MID;
        cnt_d    = '0;
        state_d  = tw_odo_pkg::ST_MOD;
      end
      tw_odo_pkg::ST_HEAD_MOD: begin
        cmd_o.op = tw_odo_pkg::OP_HEAD_MOD;
        pass_d   = tw_odo_pkg::PASS_HEAD;
        cnt_d    = '0;
        state_d  = tw_odo_pkg::ST_MOD;
      end
      tw_odo_pkg::ST_MOD: begin
        cmd_o.op = tw_odo_pkg::OP_MOD;
        if (cnt_q == CW'(MOD_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = (pass_q == tw_odo_pkg::PASS_HEAD) ? tw_odo_pkg::ST_HFIX
                                                      : tw_odo_pkg::ST_FOLD;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      tw_odo_pkg::ST_FOLD: begin
        cmd_o.op = tw_odo_pkg::OP_FOLD;
        cnt_d    = '0;
        state_d  = tw_odo_pkg::ST_CORD;
      end
      tw_odo_pkg::ST_CORD: begin
        cmd_o.op = tw_odo_pkg::OP_CORD;
        if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = tw_odo_pkg::ST_TRIG;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      tw_odo_pkg::ST_TRIG: begin
        cmd_o.op = tw_odo_pkg::OP_TRIG;
        if (pass_q == tw_odo_pkg::PASS_HALF) begin
          side_d  = 1'b0;
          state_d = tw_odo_pkg::ST_CH_MUL;
        end else begin
          state_d = tw_odo_pkg::ST_R1;
        end
      end
      tw_odo_pkg::ST_CH_MUL: begin
        cmd_o.op = tw_odo_pkg::OP_CH_MUL;
        state_d  = tw_odo_pkg::ST_DIV_INIT;
      end
      tw_odo_pkg::ST_DIV_INIT: begin
        cmd_o.op = tw_odo_pkg::OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = tw_odo_pkg::ST_DIV;
      end
      tw_odo_pkg::ST_DIV: begin
        cmd_o.op = tw_odo_pkg::OP_DIV;
        if (cnt_q == CW'(tw_odo_pkg::DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = tw_odo_pkg::ST_CH_UMUL;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      tw_odo_pkg::ST_CH_UMUL: begin
        cmd_o.op = tw_odo_pkg::OP_CH_UMUL;
        state_d  = tw_odo_pkg::ST_CH_SUM;
      end
      tw_odo_pkg::ST_CH_SUM: begin
        cmd_o.op = tw_odo_pkg::OP_CH_SUM;
        if (!side_q) begin
          side_d  = 1'b1;
          state_d = tw_odo_pkg::ST_CH_MUL;
        end else begin
          state_d = tw_odo_pkg::ST_ARG_MID;
        end
      end
      tw_odo_pkg::ST_R1: begin
        cmd_o.op = tw_odo_pkg::OP_R1;
        state_d  = tw_odo_pkg::ST_R2;
      end
      tw_odo_pkg::ST_R2: begin
        cmd_o.op = tw_odo_pkg::OP_R2;
        state_d  = tw_odo_pkg::ST_R3;
      end
      tw_odo_pkg::ST_R3: begin
        cmd_o.op = tw_odo_pkg::OP_R3;
        state_d  = tw_odo_pkg::ST_R4;
      end
      tw_odo_pkg::ST_R4: begin
        cmd_o.op = tw_odo_pkg::OP_R4;
        state_d  = tw_odo_pkg::ST_R5;
      end
      tw_odo_pkg::ST_R5: begin
        cmd_o.op = tw_odo_pkg::OP_R5;
        state_d  = tw_odo_pkg::ST_HEAD_MOD;
      end
      tw_odo_pkg::ST_HFIX: begin
        cmd_o.op = tw_odo_pkg::OP_HFIX;
        state_d  = tw_odo_pkg::ST_OUT;
      end
      tw_odo_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = tw_odo_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = tw_odo_pkg::ST_IDLE;
        end
      end
      default: state_d = tw_odo_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/tw_odo_dp.sv
// Odometry datapath: config, pose state, shared multiplier, modulo, CORDIC, divider.
module tw_odo_dp #(
  parameter int unsigned ANGLE_FRAC_BITS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tw_odo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tw_odo_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic signed [31:0]                   right_wheel_angle_i,
  input  logic signed [31:0]                   back_wheel_angle_i,
  input  logic signed [31:0]                   imu_rotation_i,
  input  tw_odo_pkg::cmd_t                     cmd_i,
  output tw_odo_pkg::sts_t                     sts_o,
  output logic signed [47:0]                   position_x_o,
  output logic signed [47:0]                   position_y_o,
  output logic signed [22:0]                   heading_o,
  output logic signed [31:0]                   heading_change_o,
  output logic signed [31:0]                   step_x_o,
  output logic signed [31:0]                   step_y_o
);

  localparam int unsigned F         = ANGLE_FRAC_BITS;
  localparam int unsigned MID_W     = 63 - F;
  localparam int unsigned ZW        = MID_W + 1;
  localparam int unsigned MOD_STEPS = 31 - F;
  localparam int unsigned DW        = 62 - F;
  localparam longint PI30  = tw_odo_pkg::pi_at(30);
  localparam longint TWO30 = 2 * PI30;
  localparam longint HALF30 = PI30 / 2;
  localparam longint PIF   = tw_odo_pkg::pi_at(int'(F));
  localparam longint TWOF  = 2 * PIF;
  localparam logic signed [ZW-1:0] PI_Z   = ZW'(PI30);
  localparam logic signed [ZW-1:0] TWO_Z  = ZW'(TWO30);
  localparam logic signed [ZW-1:0] HALF_Z = ZW'(HALF30);
  localparam logic signed [32:0]   PI_H   = 33'(PIF);
  localparam logic signed [32:0]   TWO_H  = 33'(TWOF);

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v[67:31] == {37{v[67]}}) return v[31:0];
    return v[67] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] == v[47]) return v[47:0];
    return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
  endfunction

  // configuration
  logic        [23:0] radius_q;
  logic signed [24:0] roff_q, boff_q;
  logic signed [22:0] sh_q;
  logic signed [47:0] sx_q, sy_q;
  // pose state
  logic signed [31:0] lr_q, lb_q, lh_q;
  logic signed [47:0] px_q, py_q;
  logic               primed_q;
  // working registers
  logic signed [31:0] r_q, b_q, imu_q, cur_q, dth_q;
  logic signed [31:0] dr_q, db_q, lx_q, ly_q, gx_q, gy_q;
  logic signed [66:0] prod_q, acc_q;
  logic [MID_W-1:0]   rem_q, modv_q;
  logic               mneg_q;
  logic signed [33:0] cx_q, cy_q, cz_q, c_q, s_q;
  logic               csign_q;
  logic [63:0]        dnum_q;
  logic [DW-1:0]      drem_q, dden_q;
  logic               dneg_q;
  logic [22:0]        hd_q;

  // combinational
  logic signed [31:0] cur_c, dth_c;
  logic signed [32:0] ddr_c, ddb_c;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod_c, rnd_c;
  logic signed [31:0] trv_c;
  logic signed [MID_W-1:0] arg_c;
  logic [MID_W-1:0]   amag_c;
  logic signed [ZW-1:0] z0_c, z1_c, z2_c;
  logic               zneg_c;
  logic signed [33:0] xs_c, ys_c, at_c;
  logic [DW:0]        dsh_c;
  logic               dge_c;
  logic signed [67:0] n2_c, tq_c, t_c, u_c, rsum_c, rdif_c;
  logic [31:0]        dthmag_c;
  logic signed [32:0] hd0_c, hd1_c, hd2_c;

  always_comb begin
    cur_c  = sat32(68'(sh_q) - 68'(imu_q));
    dth_c  = sat32(68'(cur_c) - 68'(lh_q));
    ddr_c  = 33'(r_q) - 33'(lr_q);
    ddb_c  = 33'(b_q) - 33'(lb_q);

    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      tw_odo_pkg::OP_MUL_R: begin
        mul_a = 34'(ddr_c);
        mul_b = $signed({9'd0, radius_q});
      end
      tw_odo_pkg::OP_MUL_B: begin
        mul_a = 34'(ddb_c);
        mul_b = $signed({9'd0, radius_q});
      end
      tw_odo_pkg::OP_CH_MUL: begin
        mul_a = s_q;
        mul_b = cmd_i.side ? 33'(dr_q) : 33'(db_q);
      end
      tw_odo_pkg::OP_CH_UMUL: begin
        mul_a = s_q;
        mul_b = cmd_i.side ? 33'(roff_q) : 33'(boff_q);
      end
      tw_odo_pkg::OP_R1: begin
        mul_a = c_q;
        mul_b = 33'(lx_q);
      end
      tw_odo_pkg::OP_R2: begin
        mul_a = s_q;
        mul_b = 33'(ly_q);
      end
      tw_odo_pkg::OP_R3: begin
        mul_a = c_q;
        mul_b = 33'(ly_q);
      end
      tw_odo_pkg::OP_R4: begin
        mul_a = s_q;
        mul_b = 33'(lx_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_c = 67'(mul_a) * 67'(mul_b);

    rnd_c = prod_q + (67'sd1 <<< (F - 1));
    trv_c = sat32(68'(rnd_c >>> F));

    // angle argument for the shared modulo unit
    case (cmd_i.op)
      tw_odo_pkg::OP_ARG_HALF: arg_c = MID_W'(dth_q) <<< (29 - F);
      tw_odo_pkg::OP_ARG_MID:  arg_c = (MID_W'(lh_q) <<< (30 - F))
                                     + (MID_W'(dth_q) <<< (29 - F));
      default:                 arg_c = MID_W'(cur_q);
    endcase
    amag_c = arg_c[MID_W-1] ? MID_W'(-arg_c) : MID_W'(arg_c);

    // bring the remainder into [-pi, pi], then into the right half plane
    z0_c = mneg_q ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});
    if (z0_c > PI_Z)       z1_c = z0_c - TWO_Z;
    else if (z0_c < -PI_Z) z1_c = z0_c + TWO_Z;
    else                   z1_c = z0_c;
    zneg_c = 1'b1;
    if (z1_c > HALF_Z)       z2_c = z1_c - PI_Z;
    else if (z1_c < -HALF_Z) z2_c = z1_c + PI_Z;
    else begin
      z2_c   = z1_c;
      zneg_c = 1'b0;
    end

    xs_c = cx_q >>> cmd_i.iter;
    ys_c = cy_q >>> cmd_i.iter;
    at_c = $signed({4'd0, tw_odo_pkg::atan_q30(cmd_i.iter)});

    // restoring divider step
    dsh_c = {drem_q, dnum_q[63]};
    dge_c = (dsh_c >= {1'b0, dden_q});

    n2_c     = 68'(prod_q) <<< 1;
    dthmag_c = dth_q[31] ? 32'(-33'(dth_q)) : 32'(dth_q);
    tq_c     = $signed({4'd0, dnum_q});
    t_c      = dneg_q ? -tq_c : tq_c;
    u_c      = 68'((prod_q + (67'sd1 <<< 28)) >>> 29);

    rsum_c = 68'(acc_q) + 68'(prod_q) + (68'sd1 <<< 29);
    rdif_c = 68'(acc_q) - 68'(prod_q) + (68'sd1 <<< 29);

    hd0_c = mneg_q ? -$signed({1'b0, rem_q[31:0]}) : $signed({1'b0, rem_q[31:0]});
    hd1_c = (hd0_c <= -PI_H) ? hd0_c + TWO_H : hd0_c;
    hd2_c = (hd1_c > PI_H) ? hd1_c - TWO_H : hd1_c;
  end

  assign sts_o.dth_zero = (dth_q == 32'sd0);

  // configuration and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      roff_q   <= '0;
      boff_q   <= '0;
      sh_q     <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      lr_q     <= '0;
      lb_q     <= '0;
      lh_q     <= '0;
      px_q     <= '0;
      py_q     <= '0;
      primed_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tw_odo_pkg::CFG_WHEEL_RADIUS:  radius_q <= cfg_data_i[23:0];
          tw_odo_pkg::CFG_RIGHT_OFFSET:  roff_q   <= cfg_data_i[24:0];
          tw_odo_pkg::CFG_BACK_OFFSET:   boff_q   <= cfg_data_i[24:0];
          tw_odo_pkg::CFG_START_HEADING: sh_q     <= cfg_data_i[22:0];
          tw_odo_pkg::CFG_START_X:       sx_q     <= cfg_data_i[47:0];
          tw_odo_pkg::CFG_START_Y:       sy_q     <= cfg_data_i[47:0];
          default: ;
        endcase
      end
      if (cmd_i.op == tw_odo_pkg::OP_LOAD && !primed_q) begin
        lh_q     <= 32'(sh_q);
        px_q     <= sx_q;
        py_q     <= sy_q;
        primed_q <= 1'b1;
      end
      if (cmd_i.op == tw_odo_pkg::OP_HFIX) begin
        px_q <= sat48(49'(px_q) + 49'(gx_q));
        py_q <= sat48(49'(py_q) + 49'(gy_q));
        lr_q <= r_q;
        lb_q <= b_q;
        lh_q <= cur_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tw_odo_pkg::OP_LOAD: begin
        r_q   <= right_wheel_angle_i;
        b_q   <= back_wheel_angle_i;
        imu_q <= imu_rotation_i;
      end
      tw_odo_pkg::OP_HEAD: begin
        cur_q <= cur_c;
        dth_q <= dth_c;
      end
      tw_odo_pkg::OP_MUL_R, tw_odo_pkg::OP_MUL_B, tw_odo_pkg::OP_CH_MUL,
      tw_odo_pkg::OP_CH_UMUL, tw_odo_pkg::OP_R1: prod_q <= prod_c;
      tw_odo_pkg::OP_TRV_R: dr_q <= trv_c;
      tw_odo_pkg::OP_TRV_B: db_q <= trv_c;
      tw_odo_pkg::OP_PLAIN: begin
        lx_q <= db_q;
        ly_q <= dr_q;
      end
      tw_odo_pkg::OP_ARG_HALF, tw_odo_pkg::OP_ARG_MID: begin
        rem_q  <= amag_c;
        mneg_q <= arg_c[MID_W-1];
        modv_q <= MID_W'(TWO30) << (MOD_STEPS - 1);
      end
      tw_odo_pkg::OP_HEAD_MOD: begin
        rem_q  <= amag_c;
        mneg_q <= arg_c[MID_W-1];
        modv_q <= MID_W'(TWOF) << (MOD_STEPS - 1);
      end
      tw_odo_pkg::OP_MOD: begin
        if (rem_q >= modv_q) rem_q <= rem_q - modv_q;
        modv_q <= modv_q >> 1;
      end
      tw_odo_pkg::OP_FOLD: begin
        cx_q    <= 34'(tw_odo_pkg::GAIN_Q30);
        cy_q    <= '0;
        cz_q    <= z2_c[33:0];
        csign_q <= zneg_c;
      end
      tw_odo_pkg::OP_CORD: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys_c;
          cy_q <= cy_q + xs_c;
          cz_q <= cz_q - at_c;
        end else begin
          cx_q <= cx_q + ys_c;
          cy_q <= cy_q - xs_c;
          cz_q <= cz_q + at_c;
        end
      end
      tw_odo_pkg::OP_TRIG: begin
        c_q <= csign_q ? -cx_q : cx_q;
        s_q <= csign_q ? -cy_q : cy_q;
      end
      tw_odo_pkg::OP_DIV_INIT: begin
        dnum_q <= n2_c[67] ? 64'(-n2_c) : 64'(n2_c);
        dneg_q <= prod_q[66] ^ dth_q[31];
        dden_q <= {dthmag_c, {(30 - F){1'b0}}};
        drem_q <= '0;
      end
      tw_odo_pkg::OP_DIV: begin
        drem_q <= dge_c ? DW'(dsh_c - {1'b0, dden_q}) : dsh_c[DW-1:0];
        dnum_q <= {dnum_q[62:0], dge_c};
      end
      tw_odo_pkg::OP_CH_SUM: begin
        if (cmd_i.side) ly_q <= sat32(t_c + u_c);
        else            lx_q <= sat32(t_c + u_c);
      end
      tw_odo_pkg::OP_R2, tw_odo_pkg::OP_R4: begin
        acc_q  <= prod_q;
        prod_q <= prod_c;
      end
      tw_odo_pkg::OP_R3: begin
        gx_q   <= sat32(rsum_c >>> 30);
        prod_q <= prod_c;
      end
      tw_odo_pkg::OP_R5: gy_q <= sat32(rdif_c >>> 30);
      tw_odo_pkg::OP_HFIX: hd_q <= hd2_c[22:0];
      tw_odo_pkg::OP_OUT: begin
        position_x_o     <= px_q;
        position_y_o     <= py_q;
        heading_o        <= hd_q;
        heading_change_o <= dth_q;
        step_x_o         <= gx_q;
        step_y_o         <= gy_q;
      end
      default: ;
    endcase
  end

endmodule

### sv/tracking_wheel_odometry.sv
// One word in flight: a new sample word is taken only after the last one has left ST_OUT.
// The bit-serial divider, run once per wheel, and the iterative CORDIC, run for the half angle
// and the mid heading, are the long steps of each word.
// A finished word waits in the output register while the next word is taken.
// Reset: asynchronous, active low; clears config, pose state and the first-step flag.
module tracking_wheel_odometry #(
  parameter int unsigned CORDIC_STEPS    = 24,
  parameter int unsigned ANGLE_FRAC_BITS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [tw_odo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tw_odo_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // sample words
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [31:0]                 right_wheel_angle_i,
  input  logic signed [31:0]                 back_wheel_angle_i,
  input  logic signed [31:0]                 imu_rotation_i,
  // pose words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [47:0]                 position_x_o,
  output logic signed [47:0]                 position_y_o,
  output logic signed [22:0]                 heading_o,
  output logic signed [31:0]                 heading_change_o,
  output logic signed [31:0]                 step_x_o,
  output logic signed [31:0]                 step_y_o
);

  tw_odo_pkg::cmd_t cmd;
  tw_odo_pkg::sts_t sts;

  // Sequencer: walks load, travel, chord (divide per wheel, on a heading change), rotation and
  // heading wrap, one datapath operation per cycle while not held in ST_OUT by a full output register.
  tw_odo_ctrl #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: one shared multiplier, a shift-subtract modulo for angle wrap,
  // a rotation-mode CORDIC and a restoring divider.
  tw_odo_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .right_wheel_angle_i (right_wheel_angle_i),
    .back_wheel_angle_i  (back_wheel_angle_i),
    .imu_rotation_i      (imu_rotation_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .position_x_o        (position_x_o),
    .position_y_o        (position_y_o),
    .heading_o           (heading_o),
    .heading_change_o    (heading_change_o),
    .step_x_o            (step_x_o),
    .step_y_o            (step_y_o)
  );

`ifndef SYNTHESIS
  // one word in flight: an accepted word drops ready on the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held after accepting a word");

  // the chord divide never runs on a zero heading change
  a_no_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == tw_odo_pkg::OP_DIV_INIT |-> !sts.dth_zero)
    else $error("divider started with zero heading change");

  // a new pose is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == tw_odo_pkg::OP_OUT |-> (!out_valid_o || out_ready_i))
    else $error("pose word overwritten before it was taken");
`endif

endmodule
